[rtl/rc4_pkg.sv]
package rc4_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_BYTES   = 32;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        CFG_KEY_WORD_0 = 3'd0,
        CFG_KEY_WORD_1 = 3'd1,
        CFG_KEY_WORD_2 = 3'd2,
        CFG_KEY_WORD_3 = 3'd3,
        CFG_KEY_LENGTH = 3'd4
    } cfg_index_t;

    // one request to the permutation memory: a write and a read
    typedef struct packed {
        logic  wr_en;
        byte_t wr_addr;
        byte_t wr_data;
        logic  rd_en;
        byte_t rd_addr;
    } sbox_req_t;

endpackage

[rtl/rc4_stream_cipher_top.sv]
// RC4 byte cipher: each accepted byte is XORed with one keystream byte, so the
// same block encrypts and decrypts.
// Input channel s_*: s_data_byte plus s_restart; a byte with s_restart set, and
// the first byte after reset, first runs key scheduling with the current key.
// Result channel m_*: one m_out_byte per input byte, in order.
// Config port: cfg_wr_en/cfg_index/cfg_wdata write key words 0..3 and the key
// length (index 4); write only while no byte is in flight.
// The result is registered in PR_OUT, after PR_J, PR_SWAP and PR_KS, and the
// next byte is taken in that same cycle, so a byte never starts before the last
// is done. The single-port-read permutation memory sets these steps: read S[i],
// read S[j], two swap writes, read the keystream entry.
// Key scheduling adds 256 identity fills, then 256 mixing steps (KS_J, KS_W1,
// KS_W2), which share the same memory.
// Reset clears the indices, the keyed flag and the key registers (length 1);
// the permutation memory is not cleared, key scheduling rewrites it.
// If the receiver stalls, the finished byte waits in the output register; one
// more input byte is taken and then held in its last step until it drains.
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_restart,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int         KI_W    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [8:0] MAX_LEN = 9'(MAX_KEY_BYTES);

    typedef enum logic [9:0] {
        IDLE     = 10'b00_0000_0001,
        INIT     = 10'b00_0000_0010,
        KS_RD    = 10'b00_0000_0100,
        KS_J     = 10'b00_0000_1000,
        KS_W1    = 10'b00_0001_0000,
        KS_W2    = 10'b00_0010_0000,
        PR_J     = 10'b00_0100_0000,
        PR_SWAP  = 10'b00_1000_0000,
        PR_KS    = 10'b01_0000_0000,
        PR_OUT   = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    byte_t             i_reg, i_next;
    byte_t             j_reg, j_next;
    byte_t             si_reg, si_next;
    byte_t             sj_reg, sj_next;
    byte_t             data_reg, data_next;
    logic [KI_W-1:0]   ki_reg, ki_next;
    logic              keyed_reg, keyed_next;
    logic              m_valid_reg, m_valid_next;
    byte_t             m_out_byte_reg, m_out_byte_next;

    logic [63:0]       key_word_reg [KEY_WORDS];
    logic [5:0]        key_len_reg;

    byte_t             key_bytes [KEY_BYTES];
    byte_t             ki8;
    byte_t             key_byte;
    logic [8:0]        len_raw;
    logic [8:0]        len_eff;
    logic              ki_wrap;
    byte_t             ks_j_sum;
    logic              out_free;
    logic              accept;
    sbox_req_t         mem_req;
    byte_t             mem_rd_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < KEY_WORDS; w++) begin
                key_word_reg[w] <= '0;
            end
            key_len_reg <= 6'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY_WORD_0: key_word_reg[0] <= cfg_wdata;
                CFG_KEY_WORD_1: key_word_reg[1] <= cfg_wdata;
                CFG_KEY_WORD_2: key_word_reg[2] <= cfg_wdata;
                CFG_KEY_WORD_3: key_word_reg[3] <= cfg_wdata;
                CFG_KEY_LENGTH: key_len_reg     <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // key byte selection, key length clamped to 1..MAX_KEY_BYTES
    always_comb begin
        for (int b = 0; b < KEY_BYTES; b++) begin
            key_bytes[b] = key_word_reg[2'(b >> 3)][(b & 7) * 8 +: 8];
        end
        ki8      = 8'(ki_reg);
        key_byte = (ki8 < 8'(KEY_BYTES)) ? key_bytes[ki8[4:0]] : 8'd0;
        len_raw  = (key_len_reg == 6'd0) ? 9'd1 : 9'(key_len_reg);
        len_eff  = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
        ki_wrap  = (9'(ki_reg) + 9'd1) >= len_eff;
        ks_j_sum = j_reg + mem_rd_data + key_byte;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE) || ((state_reg == PR_OUT) && out_free);
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        data_next       = data_reg;
        ki_next         = ki_reg;
        keyed_next      = keyed_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_out_byte_next = m_out_byte_reg;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = i_reg;
        mem_req.wr_data = i_reg;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = i_reg + 8'd1;

        case (state_reg)
            IDLE: begin
                // keep S[i+1] fetched so a new byte can start right away
                mem_req.rd_en = 1'b1;
            end
            INIT: begin
                mem_req.wr_en = 1'b1;
                i_next        = i_reg + 8'd1;
                if (i_reg == 8'hFF) begin
                    state_next = KS_RD;
                end
            end
            KS_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = i_reg;
                state_next      = KS_J;
            end
            KS_J: begin
                si_next         = mem_rd_data;
                j_next          = ks_j_sum;
                ki_next         = ki_wrap ? '0 : ki_reg + KI_W'(1);
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ks_j_sum;
                state_next      = KS_W1;
            end
            KS_W1: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = mem_rd_data;
                state_next      = KS_W2;
            end
            KS_W2: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg;
                mem_req.wr_data = si_reg;
                mem_req.rd_en   = 1'b1;
                i_next          = i_reg + 8'd1;
                if (i_reg == 8'hFF) begin
                    // scheduling done, i wraps to zero and S[1] is fetched
                    mem_req.rd_addr = 8'd1;
                    j_next          = 8'd0;
                    keyed_next      = 1'b1;
                    state_next      = PR_J;
                end else begin
                    state_next = KS_J;
                end
            end
            PR_J: begin
                si_next         = mem_rd_data;
                i_next          = i_reg + 8'd1;
                j_next          = j_reg + mem_rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = j_reg + mem_rd_data;
                state_next      = PR_SWAP;
            end
            PR_SWAP: begin
                sj_next         = mem_rd_data;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = mem_rd_data;
                state_next      = PR_KS;
            end
            PR_KS: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg;
                mem_req.wr_data = si_reg;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = si_reg + sj_reg;
                state_next      = PR_OUT;
            end
            PR_OUT: begin
                // read data holds while the output register is full
                if (out_free) begin
                    mem_req.rd_en   = 1'b1;
                    m_valid_next    = 1'b1;
                    m_out_byte_next = data_reg ^ mem_rd_data;
                    state_next      = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        if (accept) begin
            data_next = s_data_byte;
            if (s_restart || !keyed_reg) begin
                i_next     = 8'd0;
                j_next     = 8'd0;
                ki_next    = '0;
                state_next = INIT;
            end else begin
                state_next = PR_J;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            i_reg       <= 8'd0;
            j_reg       <= 8'd0;
            ki_reg      <= '0;
            keyed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            ki_reg      <= ki_next;
            keyed_reg   <= keyed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        si_reg         <= si_next;
        sj_reg         <= sj_next;
        data_reg       <= data_next;
        m_out_byte_reg <= m_out_byte_next;
    end

    rc4_sbox_ram u_sbox (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;

    // end of key scheduling leaves both indices cleared and the key marked loaded
    a_ks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == KS_W2) && (i_reg == 8'hFF)
        |=> (i_reg == 8'd0) && (j_reg == 8'd0) && keyed_reg && (state_reg == PR_J))
        else $error("key scheduling did not finish cleanly");

    // a byte on a keyed table goes straight to the generator
    a_fast_path: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_restart && keyed_reg |=> state_reg == PR_J)
        else $error("keyed byte did not start the generator");

    // a new result only comes from the last generator step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) |-> $past(state_reg == PR_OUT))
        else $error("result loaded outside the output step");

    // keystream byte stays put while the output register is blocked
    a_ks_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PR_OUT) && m_valid && !m_ready
        |=> (state_reg == PR_OUT) && $stable(mem_rd_data))
        else $error("keystream byte lost during output stall");

endmodule

[rtl/rc4_sbox_ram.sv]
module rc4_sbox_ram
    import rc4_pkg::*;
(
    input  logic      aclk,
    input  sbox_req_t req,
    output byte_t     rd_data
);

    byte_t mem [TABLE_DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // write-first bypass when the same entry is read and written in the same cycle
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
                rd_data_reg <= req.wr_data;
            end else begin
                rd_data_reg <= mem[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/tb_rc4_stream_cipher_top.sv]
module tb_rc4_stream_cipher_top
    import rc4_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TOTAL_BYTES    = 1550;
    localparam int          CYCLE_LIMIT    = 8_000_000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [2:0]  CFG_INDEX_TOP  = 3'd7;

    // keystream predictor plus the queue of expected output bytes
    class rc4_keystream_scoreboard;
        byte_t       perm[TABLE_DEPTH];
        byte_t       idx_i;
        byte_t       idx_j;
        bit          keyed;
        logic [63:0] key_words[KEY_WORDS];
        logic [5:0]  key_len;
        byte_t       expected_bytes[$];
        int          mismatches;

        function new();
            foreach (key_words[k]) key_words[k] = '0;
            foreach (perm[k]) perm[k] = '0;
            key_len    = 6'd1;
            idx_i      = '0;
            idx_j      = '0;
            keyed      = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [63:0] val);
            if (idx < CFG_KEY_LENGTH)
                key_words[idx[1:0]] = val;
            else if (idx == CFG_KEY_LENGTH)
                key_len = val[5:0];
        endfunction

        function void schedule_key();
            int unsigned len;
            int unsigned ki;
            byte_t       j;
            byte_t       t;
            byte_t       kb;
            len = key_len;
            if (len == 0) len = 1;
            if (len > KEY_BYTES) len = KEY_BYTES;
            for (int n = 0; n < TABLE_DEPTH; n++) perm[n] = byte_t'(n);
            j  = '0;
            ki = 0;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                kb = key_words[ki >> 3][8 * (ki & 7) +: 8];
                j = j + perm[n] + kb;
                t = perm[n];
                perm[n] = perm[j];
                perm[j] = t;
                ki++;
                if (ki >= len) ki = 0;
            end
            idx_i = '0;
            idx_j = '0;
            keyed = 1'b1;
        endfunction

        function void note_input(byte_t data, logic restart);
            byte_t t;
            byte_t ks_addr;
            if (restart || !keyed) schedule_key();
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + perm[idx_i];
            t = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            ks_addr = perm[idx_i] + perm[idx_j];
            expected_bytes.push_back(data ^ perm[ks_addr]);
        endfunction

        function void check_output(byte_t got);
            byte_t want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output byte %02h at %0t", got, $realtime);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("out_byte mismatch at %0t: expected %02h got %02h",
                             $realtime, want, got);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_restart   = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [63:0] cfg_wdata   = '0;

    rc4_keystream_scoreboard sb;
    bit          no_idle    = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;

    rc4_stream_cipher_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // valid stays high across back-to-back transfers, lowered only for a gap or by idle_wait
    task automatic send_byte(input byte_t data, input logic restart);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_restart   <= restart;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(data, restart);
        bytes_sent++;
    endtask

    task automatic idle_wait();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_register(idx, val);
    endtask

    task automatic finish_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // result side
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_output(m_out_byte);
        end
    end

    initial begin
        int          count;
        bit          fresh;
        logic [63:0] val;

        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero key of length 1, first byte keys the table without restart
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b1);
        idle_wait();

        // all-ones key at full length
        write_register(CFG_KEY_WORD_0, '1);
        write_register(CFG_KEY_WORD_1, '1);
        write_register(CFG_KEY_WORD_2, '1);
        write_register(CFG_KEY_WORD_3, '1);
        write_register(CFG_KEY_LENGTH, 64'd32);
        finish_writes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        idle_wait();

        // zero length behaves as length 1
        write_register(CFG_KEY_LENGTH, 64'd0);
        finish_writes();
        send_byte(8'h7E, 1'b1);
        send_byte(8'h01, 1'b0);
        idle_wait();

        // lengths above the maximum clamp, upper data bits dropped
        write_register(CFG_KEY_LENGTH, '1);
        finish_writes();
        send_byte(8'h80, 1'b1);
        send_byte(8'h10, 1'b0);
        idle_wait();
        write_register(CFG_KEY_LENGTH, 64'd33);
        finish_writes();
        send_byte(8'h42, 1'b1);
        idle_wait();

        // writes past the last register change nothing
        for (int k = CFG_KEY_LENGTH + 1; k <= CFG_INDEX_TOP; k++)
            write_register(3'(k), '1);
        write_register(CFG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFC1);
        finish_writes();
        send_byte(8'hC3, 1'b1);
        send_byte(8'h99, 1'b0);
        idle_wait();

        // distinct byte pattern, key changed without restart first
        write_register(CFG_KEY_WORD_0, 64'h0706_0504_0302_0100);
        write_register(CFG_KEY_WORD_1, 64'h0F0E_0D0C_0B0A_0908);
        write_register(CFG_KEY_LENGTH, 64'd16);
        finish_writes();
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);

        while (bytes_sent < TOTAL_BYTES) begin
            idle_wait();
            no_idle = ($urandom_range(0, 5) == 0);
            for (int k = CFG_KEY_WORD_0; k <= CFG_KEY_WORD_3; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 7))
                        0:       val = '0;
                        1:       val = '1;
                        default: val = {$urandom, $urandom};
                    endcase
                    write_register(3'(k), val);
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                val = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0:       val[5:0] = 6'd0;
                    1:       val[5:0] = 6'd32;
                    2:       val[5:0] = 6'd63;
                    3:       val[5:0] = 6'd33;
                    4:       val[5:0] = 6'd1;
                    default: val[5:0] = 6'($urandom_range(1, 32));
                endcase
                write_register(CFG_KEY_LENGTH, val);
            end
            finish_writes();
            // mostly a fresh message, sometimes the old stream carries on
            fresh = ($urandom_range(0, 3) != 0);
            count = $urandom_range(10, 80);
            for (int n = 0; n < count; n++)
                send_byte(byte_t'($urandom_range(0, 255)),
                          (n == 0 && fresh) || ($urandom_range(0, 49) == 0));
        end

        idle_wait();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rc4_pkg.sv
rtl/rc4_sbox_ram.sv
rtl/rc4_stream_cipher_top.sv
tb/tb_rc4_stream_cipher_top.sv
